// ===== sv/atl_pkg.sv =====
// Shared constants, types and tables of the ADC-to-lux converter.
// Depends on nothing; every other file of the block takes names from here.
`default_nettype none

package atl_pkg;

	localparam int ADC_BITS_DEF = 10;
	localparam int R1_W         = 20;
	localparam int COEF_W       = 16;
	localparam int LUX_W        = 25;
	localparam int FRAC_W       = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 20;

	localparam logic [LUX_W-1:0] LUX_MAX = '1;

	localparam logic [R1_W-1:0]          R1_RST    = 20'd10000;
	localparam logic signed [COEF_W-1:0] SLOPE_RST = -16'sd3072;
	localparam logic signed [COEF_W-1:0] ICPT_RST  = 16'sd24576;

	// log10(2) in Q30 and log2(10) in Q28.
	localparam logic signed [30:0] LOG10_2_Q30 = 31'sd323228497;
	localparam logic signed [31:0] LOG2_10_Q28 = 32'sd891723283;

	// Exponent clamp of +/-8.0 in Q16.
	localparam int EXP_LIMIT = 8 * 65536;

	// 2^(2^-(k+1)) in Q30 for entry k, most significant fraction bit first.
	localparam logic [30:0] POW2_FRAC_Q30 [FRAC_W] = '{
		31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
		31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
		31'd1075196443, 31'd1074468887, 31'd1074105294, 31'd1073923544,
		31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
	};

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DARK   = 2'd1,
		ST_SAT    = 2'd2,
		ST_SLOPE0 = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_R1    = 2'd0,
		REG_SLOPE = 2'd1,
		REG_ICPT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic zero_code;
		logic zero_res;
	} flags_t;

	typedef struct packed {
		logic [LUX_W-1:0] lux;
		status_t          status;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/atl_if.sv =====
// Handshake channels of the ADC-to-lux converter: samples, results and
// configuration writes. Depends on atl_pkg for widths.
`default_nettype none

interface atl_sample_if #(parameter int ADC_BITS = atl_pkg::ADC_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_code;
	modport source (output valid, output adc_code, input ready);
	modport sink   (input valid, input adc_code, output ready);
endinterface

interface atl_result_if;
	logic                        valid;
	logic                        ready;
	logic [atl_pkg::LUX_W-1:0]   lux_q8;
	logic [1:0]                  status;
	modport source (output valid, output lux_q8, output status, input ready);
	modport sink   (input valid, input lux_q8, input status, output ready);
endinterface

interface atl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [atl_pkg::CFG_IDX_W-1:0]    index;
	logic [atl_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/adc_to_lux_converter.sv =====
// Top level of the ADC-to-lux converter: a fixed-point log/exp pipeline.
// Depends on atl_pkg and on the channel interfaces in atl_if.sv.
//
//  channel   dir  payload                  notes
//  samples   in   adc_code[ADC_BITS-1:0]   one item per cycle while ready
//  results   out  lux_q8[24:0], status     output register plus one skid entry
//  cfg       in   index[1:0], data[19:0]   always ready, write only when idle
//
// One item enters per cycle while samples.ready is high. The pipeline depth
// is set by the two 16-step squaring chains of the logarithms, the
// one-bit-per-stage divider and the 16-step exponent chain. Reset restores
// the register defaults and clears all valid bits. While a result waits, one
// further item parks in the skid entry; only then does samples.ready fall
// and the whole pipeline hold.
`default_nettype none

module adc_to_lux_converter #(
	parameter int ADC_BITS = atl_pkg::ADC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	atl_sample_if.sink        samples,
	atl_result_if.source      results,
	atl_cfg_if.sink           cfg
);

	localparam int NUM_W  = atl_pkg::R1_W + ADC_BITS;
	localparam int EA_W   = $clog2(NUM_W);
	localparam int EB_W   = $clog2(ADC_BITS);
	localparam int FW     = atl_pkg::FRAC_W;
	localparam int CW     = atl_pkg::COEF_W;
	localparam int LG_W   = EA_W + FW + 1;
	localparam int PR_W   = LG_W + 31;
	localparam int D_W    = ((LG_W > CW + 4) ? LG_W : CW + 4) + 1;
	localparam int DV_W   = D_W + 12;
	localparam int E_W    = 21;
	localparam int PX_W   = E_W + 32;
	localparam int P_W    = PX_W - 28;
	localparam int Q_W    = P_W + 1;
	localparam int IP_W   = Q_W - 16;
	localparam int SUM_W  = 56;
	localparam int NSTAGE = 41 + DV_W;

	localparam logic [ADC_BITS-1:0]  FULL    = '1;
	localparam logic signed [IP_W-1:0] IP_SAT  = IP_W'(25);
	localparam logic signed [IP_W-1:0] IP_SH30 = IP_W'(30);

	// Configuration registers.
	logic [atl_pkg::R1_W-1:0] r1_q;
	logic signed [CW-1:0]     m_q;
	logic signed [CW-1:0]     b_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_q <= atl_pkg::R1_RST;
			m_q  <= atl_pkg::SLOPE_RST;
			b_q  <= atl_pkg::ICPT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				atl_pkg::REG_R1:    r1_q <= cfg.data;
				atl_pkg::REG_SLOPE: m_q  <= cfg.data[CW-1:0];
				atl_pkg::REG_ICPT:  b_q  <= cfg.data[CW-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_v_q, out_v_q;
	logic [NSTAGE-1:0] vld_q;
	atl_pkg::flags_t fl_q [NSTAGE-1];

	assign en            = !skid_v_q;
	assign samples.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], samples.valid};
		end
	end

	// Stage 1: divider numerator r1*(FULL-c) and the special-case flags.
	logic [ADC_BITS-1:0] code_s1;
	logic [NUM_W-1:0]    num_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			code_s1            <= samples.adc_code;
			num_s1             <= NUM_W'(r1_q) * NUM_W'(FULL - samples.adc_code);
			fl_q[0].zero_code  <= (samples.adc_code == '0);
			fl_q[0].zero_res   <= (r1_q == '0) || (samples.adc_code == FULL);
			for (int i = 1; i < NSTAGE - 1; i++) begin
				fl_q[i] <= fl_q[i-1];
			end
		end
	end

	// Stage 2 (index 0 of the squaring chain): leading-one normalisation.
	logic [EA_W-1:0]       ea_n;
	logic [EB_W-1:0]       eb_n;
	logic [NUM_W+30:0]     ext_a;
	logic [ADC_BITS+30:0]  ext_b;

	always_comb begin
		ea_n = '0;
		for (int i = 0; i < NUM_W; i++) begin
			if (num_s1[i]) ea_n = EA_W'(i);
		end
		eb_n = '0;
		for (int i = 0; i < ADC_BITS; i++) begin
			if (code_s1[i]) eb_n = EB_W'(i);
		end
	end

	assign ext_a = {num_s1, 31'b0} >> ea_n;
	assign ext_b = {code_s1, 31'b0} >> eb_n;

	logic [31:0]     ya_s2 [FW+1];
	logic [31:0]     yb_s2 [FW+1];
	logic [FW-1:0]   fa_s2 [FW+1];
	logic [FW-1:0]   fb_s2 [FW+1];
	logic [EA_W-1:0] ea_s2 [FW+1];
	logic [EB_W-1:0] eb_s2 [FW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ya_s2[0] <= ext_a[31:0];
			yb_s2[0] <= ext_b[31:0];
			fa_s2[0] <= '0;
			fb_s2[0] <= '0;
			ea_s2[0] <= ea_n;
			eb_s2[0] <= eb_n;
		end
	end

	// Each squaring step yields one fraction bit of both logarithms.
	for (genvar k = 0; k < FW; k++) begin : g_sq
		logic [63:0] pa, pb;
		assign pa = 64'(ya_s2[k]) * 64'(ya_s2[k]);
		assign pb = 64'(yb_s2[k]) * 64'(yb_s2[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				ya_s2[k+1] <= pa[63] ? pa[63:32] : pa[62:31];
				yb_s2[k+1] <= pb[63] ? pb[63:32] : pb[62:31];
				fa_s2[k+1] <= {fa_s2[k][FW-2:0], pa[63]};
				fb_s2[k+1] <= {fb_s2[k][FW-2:0], pb[63]};
				ea_s2[k+1] <= ea_s2[k];
				eb_s2[k+1] <= eb_s2[k];
			end
		end
	end

	// Stage 3: log2 R; stage 4: scaled to log10 before rounding.
	logic signed [LG_W-1:0] lg_s3;
	logic signed [PR_W-1:0] pl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			lg_s3 <= LG_W'({ea_s2[FW], fa_s2[FW]}) - LG_W'({eb_s2[FW], fb_s2[FW]});
			pl_s4 <= PR_W'(lg_s3) * PR_W'(atl_pkg::LOG10_2_Q30) + (PR_W'(1) << 29);
		end
	end

	// Divider set-up: d = log10 R - 16*b, then |d*4096| / |m|.
	logic signed [LG_W:0]  l10;
	logic signed [D_W-1:0] dd;
	logic [D_W-1:0]        dmag;
	logic [CW-1:0]         mmag;

	assign l10  = $signed(pl_s4[PR_W-1:30]);
	assign dd   = D_W'(l10) - (D_W'(b_q) <<< 4);
	assign dmag = dd[D_W-1] ? D_W'(-dd) : D_W'(dd);
	assign mmag = m_q[CW-1] ? CW'(-m_q) : CW'(m_q);

	// The dividend shifts out at the top while quotient bits enter below.
	logic [DV_W-1:0] dq_s5  [DV_W+1];
	logic [CW-1:0]   rm_s5  [DV_W+1];
	logic            neg_s5 [DV_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s5[0]  <= {dmag, 12'b0};
			rm_s5[0]  <= '0;
			neg_s5[0] <= dd[D_W-1] ^ m_q[CW-1];
		end
	end

	for (genvar k = 0; k < DV_W; k++) begin : g_div
		logic [CW:0] r2;
		logic        ge;
		assign r2 = {rm_s5[k], dq_s5[k][DV_W-1]};
		assign ge = (r2 >= {1'b0, mmag});
		always_ff @(posedge clk) begin
			if (en) begin
				rm_s5[k+1]  <= ge ? CW'(r2 - {1'b0, mmag}) : r2[CW-1:0];
				dq_s5[k+1]  <= {dq_s5[k][DV_W-2:0], ge};
				neg_s5[k+1] <= neg_s5[k];
			end
		end
	end

	// Stage 6: clamped, signed exponent; stage 7: times log2(10).
	logic [DV_W-1:0]        quo;
	logic [E_W-1:0]         cq;
	logic signed [E_W-1:0]  e_s6;
	logic signed [PX_W-1:0] px_s7;

	assign quo = dq_s5[DV_W];
	assign cq  = (quo > DV_W'(atl_pkg::EXP_LIMIT)) ? E_W'(atl_pkg::EXP_LIMIT) : E_W'(quo);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s6  <= neg_s5[DV_W] ? -$signed(cq) : $signed(cq);
			px_s7 <= PX_W'(e_s6) * PX_W'(atl_pkg::LOG2_10_Q28) + (PX_W'(1) << 27);
		end
	end

	// Exponent chain: index 0 splits log2 lux, offset by 8 for the Q8 output, into integer part and fraction.
	logic signed [P_W-1:0] pp;
	logic signed [Q_W-1:0] qq;

	assign pp = $signed(px_s7[PX_W-1:28]);
	assign qq = Q_W'(pp) + Q_W'(atl_pkg::EXP_LIMIT);

	logic [31:0]            v_s8   [FW+1];
	logic [FW-1:0]          f_s8   [FW+1];
	logic signed [IP_W-1:0] ip_s8  [FW+1];
	logic                   sat_s8 [FW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			v_s8[0]   <= 32'd1 << 30;
			f_s8[0]   <= qq[FW-1:0];
			ip_s8[0]  <= $signed(qq[Q_W-1:16]);
			sat_s8[0] <= ($signed(qq[Q_W-1:16]) >= IP_SAT);
		end
	end

	for (genvar k = 0; k < FW; k++) begin : g_exp
		logic [63:0] pv;
		assign pv = 64'(v_s8[k]) * 64'(atl_pkg::POW2_FRAC_Q30[k]) + (64'd1 << 29);
		always_ff @(posedge clk) begin
			if (en) begin
				v_s8[k+1]   <= f_s8[k][FW-1-k] ? pv[61:30] : v_s8[k];
				f_s8[k+1]   <= f_s8[k];
				ip_s8[k+1]  <= ip_s8[k];
				sat_s8[k+1] <= sat_s8[k];
			end
		end
	end

	// Final stage: rounding shift and selection of the status.
	logic signed [IP_W-1:0] shf;
	logic [5:0]             sh;
	logic [SUM_W-1:0]       sum;
	logic [SUM_W-1:0]       luxw;
	atl_pkg::flags_t        fl_last;
	atl_pkg::result_t       res_n, res_s9;

	assign shf     = IP_SH30 - ip_s8[FW];
	assign sh      = shf[5:0];
	assign sum     = SUM_W'(v_s8[FW]) + (SUM_W'(1) << (sh - 6'd1));
	assign luxw    = sum >> sh;
	assign fl_last = fl_q[NSTAGE-2];

	always_comb begin
		res_n.lux    = '0;
		res_n.status = atl_pkg::ST_OK;
		if (m_q == '0) begin
			res_n.status = atl_pkg::ST_SLOPE0;
		end else if (fl_last.zero_code) begin
			res_n.status = atl_pkg::ST_DARK;
		end else if (fl_last.zero_res) begin
			if (m_q[CW-1]) begin
				res_n.lux    = atl_pkg::LUX_MAX;
				res_n.status = atl_pkg::ST_SAT;
			end
		end else if (sat_s8[FW] || (luxw > SUM_W'(atl_pkg::LUX_MAX))) begin
			res_n.lux    = atl_pkg::LUX_MAX;
			res_n.status = atl_pkg::ST_SAT;
		end else begin
			res_n.lux = luxw[atl_pkg::LUX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s9 <= res_n;
		end
	end

	// Output register with one skid entry behind it.
	atl_pkg::result_t out_q, skid_q;
	logic take_skid, take_pipe, park;

	assign take_skid = skid_v_q && results.ready;
	assign take_pipe = !skid_v_q && vld_q[NSTAGE-1] && (!out_v_q || results.ready);
	assign park      = !skid_v_q && vld_q[NSTAGE-1] && out_v_q && !results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (take_skid) begin
				skid_v_q <= 1'b0;
			end else if (park) begin
				skid_v_q <= 1'b1;
			end
			if (take_pipe) begin
				out_v_q <= 1'b1;
			end else if (!skid_v_q && !park && results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_skid) begin
			out_q <= skid_q;
		end else if (take_pipe) begin
			out_q <= res_s9;
		end
		if (park) begin
			skid_q <= res_s9;
		end
	end

	assign results.valid  = out_v_q;
	assign results.lux_q8 = out_q.lux;
	assign results.status = out_q.status;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds an item while the output register is empty");

	a_sat_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.status == atl_pkg::ST_SAT) |->
			(results.lux_q8 == atl_pkg::LUX_MAX))
		else $error("saturated status without full-scale lux");

	a_clamp_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.status == atl_pkg::ST_DARK ||
			results.status == atl_pkg::ST_SLOPE0)) |-> (results.lux_q8 == '0))
		else $error("dark or zero-slope status with non-zero lux");

endmodule

`default_nettype wire

// ===== tb/tb_adc_to_lux_converter.sv =====
// Self-checking testbench of the ADC-to-lux converter: drives random and directed
// samples under several register settings and checks every result against a predictor.
// Depends on atl_pkg, the channel interfaces in atl_if.sv and the converter top level.
`default_nettype none

module tb_adc_to_lux_converter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CODE_W = atl_pkg::ADC_BITS_DEF;
	localparam logic [CODE_W-1:0] CODE_FULL = '1;

	localparam longint unsigned POW2_TAB [16] = '{
		1518500250, 1276901417, 1170923762, 1121280436,
		1097253708, 1085434106, 1079572136, 1076653033,
		1075196443, 1074468887, 1074105294, 1073923544,
		1073832680, 1073787251, 1073764537, 1073753181
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	atl_sample_if #(.ADC_BITS(CODE_W)) smp ();
	atl_result_if res ();
	atl_cfg_if    cfg_ch ();

	adc_to_lux_converter #(.ADC_BITS(CODE_W)) dut (
		.clk(clk), .arst_n(arst_n), .samples(smp), .results(res), .cfg(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Copy of the register file as the block should hold it.
	logic [atl_pkg::R1_W-1:0]          r1_now    = atl_pkg::R1_RST;
	logic signed [atl_pkg::COEF_W-1:0] slope_now = atl_pkg::SLOPE_RST;
	logic signed [atl_pkg::COEF_W-1:0] icpt_now  = atl_pkg::ICPT_RST;

	logic [CODE_W-1:0]  code_queue [$];
	atl_pkg::result_t   lux_expected [$];
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 hold_left = 0;
	logic               hold_kick = 1'b0;
	int                 mismatches = 0;

	// Q16 log2 of a positive integer: leading one, then 16 repeated squarings.
	function automatic longint log2_q16(input longint unsigned x);
		int e;
		longint unsigned y;
		longint unsigned frac;
		e = 63;
		frac = 0;
		while (x[e] == 1'b0)
			e--;
		y = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= (64'd1 << 32)) begin
				frac = frac | 1;
				y = y >> 1;
			end
		end
		return longint'(e) * 65536 + longint'(frac);
	endfunction

	function automatic atl_pkg::result_t lux_from_code(input logic [CODE_W-1:0] code);
		atl_pkg::result_t r;
		longint m, b, lg, l10, d, e, p, q, ip;
		longint unsigned num, v, lux, f;
		int shift;
		m = longint'(slope_now);
		b = longint'(icpt_now);
		r.lux = '0;
		r.status = atl_pkg::ST_OK;
		if (m == 0) begin
			r.status = atl_pkg::ST_SLOPE0;
			return r;
		end
		if (code == 0) begin
			r.status = atl_pkg::ST_DARK;
			return r;
		end
		num = longint'(r1_now) * longint'(CODE_FULL - code);
		if (num == 0) begin
			if (m < 0) begin
				r.lux = atl_pkg::LUX_MAX;
				r.status = atl_pkg::ST_SAT;
			end
			return r;
		end
		lg = log2_q16(num) - log2_q16(longint'(code));
		l10 = (lg * 323228497 + (64'sd1 <<< 29)) >>> 30;
		d = l10 - b * 16;
		e = (d * 4096) / m;
		if (e > atl_pkg::EXP_LIMIT)
			e = atl_pkg::EXP_LIMIT;
		if (e < -atl_pkg::EXP_LIMIT)
			e = -atl_pkg::EXP_LIMIT;
		p = (e * 891723283 + (64'sd1 <<< 27)) >>> 28;
		q = p + 8 * 65536;
		ip = q >>> 16;
		f = q - ip * 65536;
		if (ip >= 25) begin
			r.lux = atl_pkg::LUX_MAX;
			r.status = atl_pkg::ST_SAT;
			return r;
		end
		v = 64'd1 << 30;
		for (int k = 0; k < 16; k++) begin
			if (f[15-k])
				v = (v * POW2_TAB[k] + (64'd1 << 29)) >> 30;
		end
		shift = 30 - int'(ip);
		if (shift >= 63)
			lux = 0;
		else
			lux = (v + (64'd1 << (shift - 1))) >> shift;
		if (lux > longint'(atl_pkg::LUX_MAX)) begin
			r.lux = atl_pkg::LUX_MAX;
			r.status = atl_pkg::ST_SAT;
			return r;
		end
		r.lux = lux[atl_pkg::LUX_W-1:0];
		return r;
	endfunction

	initial begin
		smp.valid = 1'b0;
		smp.adc_code = '0;
		res.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = atl_pkg::REG_R1;
		cfg_ch.data = '0;
	end

	// Sample driver: an item is predicted at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else begin
			if (smp.valid && smp.ready)
				lux_expected.push_back(lux_from_code(smp.adc_code));
			if (!smp.valid || smp.ready) begin
				if (code_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					smp.valid <= 1'b1;
					smp.adc_code <= code_queue.pop_front();
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted separately from the random stalls.
	always @(posedge clk) begin
		if (hold_kick)
			hold_left <= 400;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (lux_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result lux=%0d status=%0d", res.lux_q8, res.status);
				end else begin
					atl_pkg::result_t want;
					want = lux_expected.pop_front();
					if (res.lux_q8 !== want.lux || res.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: lux exp %0d got %0d, status exp %0d got %0d",
								want.lux, res.lux_q8, want.status, res.status);
					end
				end
			end
			res.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(input atl_pkg::reg_idx_t idx,
			input logic [atl_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			atl_pkg::REG_R1:    r1_now = value;
			atl_pkg::REG_SLOPE: slope_now = value[atl_pkg::COEF_W-1:0];
			atl_pkg::REG_ICPT:  icpt_now = value[atl_pkg::COEF_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_coefs(input logic [atl_pkg::R1_W-1:0] r1, input logic [15:0] slope,
			input logic [15:0] icpt);
		// Upper data bits are junk for the 16-bit registers; the block must mask them.
		write_reg(atl_pkg::REG_R1, r1);
		write_reg(atl_pkg::REG_SLOPE, {4'($urandom), slope});
		write_reg(atl_pkg::REG_ICPT, {4'($urandom), icpt});
	endtask

	task automatic drain();
		while (code_queue.size() != 0 || smp.valid || lux_expected.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic load_random(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(9);
			if (pick == 0)
				code_queue.push_back(pick[0] ? CODE_FULL : '0);
			else if (pick == 1)
				code_queue.push_back($urandom_range(1) ? CODE_FULL : CODE_W'($urandom_range(3)));
			else if (pick == 2)
				code_queue.push_back(CODE_FULL - CODE_W'($urandom_range(3)));
			else
				code_queue.push_back(CODE_W'($urandom));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults first, with the boundary codes and alternating bit patterns.
		code_queue = '{0, 1, 2, 3, 511, 512, 1021, 1022, 1023, 10'h155, 10'h2AA, 100};
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_coefs(20'd1, 16'h8000, 16'h8000);
				1: set_coefs(20'hFFFFF, 16'h7FFF, 16'h7FFF);
				2: set_coefs(20'd10000, 16'h0000, 16'h1234);
				3: set_coefs(20'd0, 16'hF400, 16'h6000);
				4: set_coefs(20'd0, 16'h0C00, 16'h6000);
				5: set_coefs(20'd1, 16'h0001, 16'h7FFF);
				6: set_coefs(20'hFFFFF, 16'hFFFF, 16'h8000);
				default: set_coefs(atl_pkg::R1_W'($urandom_range(1, 200000)),
					16'(-$urandom_range(256, 8000)), 16'($urandom));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			load_random((ph == 2 || ph == 3 || ph == 4) ? 40 : 100);
			if (ph == 0) begin
				// Receiver holds off while the sender keeps offering: the pipeline fills.
				hold_kick <= 1'b1;
				@(posedge clk);
				hold_kick <= 1'b0;
			end
			drain();
		end

		// Back to the reset slope to close with ordinary readings.
		set_coefs(20'd10000, 16'hF400, 16'h6000);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_random(60);
		drain();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
